FILE: hw/rtl/dmr_pkg.sv
// ----------------------------------------------------------------------------
// Decimal mantissa rounding package
// Widths, constants and the controller/datapath interface types shared by
// the decimal mantissa round-half-even unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dmr_pkg;

    localparam int MANT_W      = 192;
    localparam int WORD_W      = 64;
    localparam int FIT_W       = 96;
    localparam int HIGH_W      = FIT_W - WORD_W;
    localparam int SCALE_IN_W  = 8;
    localparam int SCALE_OUT_W = 5;
    localparam int CHUNK_W     = 16;
    localparam int NUM_CHUNKS  = MANT_W / CHUNK_W;
    localparam int FIT_CHUNKS  = FIT_W / CHUNK_W;
    localparam int IDX_W       = $clog2(NUM_CHUNKS);
    localparam int DIGIT_W     = 4;
    localparam int CUR_W       = CHUNK_W + DIGIT_W;
    localparam int PROD_W      = 2 * CUR_W;

    localparam logic [SCALE_IN_W-1:0] MAX_SCALE   = 8'd28;
    localparam logic [DIGIT_W-1:0]    HALF_DIGIT  = 4'd5;
    localparam logic [CUR_W-1:0]      RECIP_TEN   = 20'd838861;
    localparam int                    RECIP_SHIFT = 23;

    localparam logic [IDX_W-1:0] TOP_IDX_WIDE   = IDX_W'(NUM_CHUNKS - 1);
    localparam logic [IDX_W-1:0] TOP_IDX_NARROW = IDX_W'(FIT_CHUNKS - 1);

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic round_step;
        logic set_ovf;
        logic out_load;
    } dmr_cmd_t;

    typedef struct packed {
        logic need_step;
        logic scale_zero;
        logic idx_zero;
        logic out_free;
    } dmr_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmr_datapath.sv
// ----------------------------------------------------------------------------
// Decimal mantissa rounding datapath
// Holds the mantissa, scale and sign, divides by ten one 16-bit chunk per
// cycle, applies the round-half-even increment and keeps the output item.
// ----------------------------------------------------------------------------
`default_nettype none

module dmr_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire dmr_pkg::dmr_cmd_t                     cmd,
    output dmr_pkg::dmr_sts_t                          sts,
    input  wire logic [dmr_pkg::WORD_W-1:0]            mant_word0,
    input  wire logic [dmr_pkg::WORD_W-1:0]            mant_word1,
    input  wire logic [dmr_pkg::WORD_W-1:0]            mant_word2,
    input  wire logic [dmr_pkg::SCALE_IN_W-1:0]        scale_in,
    input  wire logic                                  sign_in,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [dmr_pkg::WORD_W-1:0]                 result_low,
    output logic [dmr_pkg::HIGH_W-1:0]                 result_high,
    output logic [dmr_pkg::SCALE_OUT_W-1:0]            scale_out,
    output logic                                       sign_out,
    output logic                                       overflow
);

    logic [dmr_pkg::MANT_W-1:0]      mant_reg, mant_next;
    logic [dmr_pkg::SCALE_IN_W-1:0]  scale_reg, scale_next;
    logic                            sign_reg;
    logic                            ovf_reg, ovf_next;
    logic [dmr_pkg::DIGIT_W-1:0]     rem_reg, rem_next;
    logic [dmr_pkg::IDX_W-1:0]       idx_reg, idx_next;

    logic                            out_valid_reg;
    logic [dmr_pkg::WORD_W-1:0]      res_low_reg;
    logic [dmr_pkg::HIGH_W-1:0]      res_high_reg;
    logic [dmr_pkg::SCALE_OUT_W-1:0] scale_out_reg;
    logic                            sign_out_reg;
    logic                            ovf_out_reg;

    logic [dmr_pkg::CHUNK_W-1:0]     chunk;
    logic [dmr_pkg::CUR_W-1:0]       cur;
    logic [dmr_pkg::PROD_W-1:0]      prod;
    logic [dmr_pkg::CHUNK_W-1:0]     quot;
    logic [dmr_pkg::CUR_W-1:0]       quot_ten;
    logic [dmr_pkg::CUR_W-1:0]       diff;
    logic                            round_up;
    logic                            wide;

    assign wide     = |mant_reg[dmr_pkg::MANT_W-1:dmr_pkg::FIT_W];
    assign chunk    = mant_reg[idx_reg*dmr_pkg::CHUNK_W +: dmr_pkg::CHUNK_W];
    assign cur      = {rem_reg, chunk};
    assign prod     = cur * dmr_pkg::RECIP_TEN;
    assign quot     = prod[dmr_pkg::RECIP_SHIFT +: dmr_pkg::CHUNK_W];
    assign quot_ten = ({{dmr_pkg::DIGIT_W{1'b0}}, quot} << 3)
                    + ({{dmr_pkg::DIGIT_W{1'b0}}, quot} << 1);
    assign diff     = cur - quot_ten;
    assign round_up = (rem_reg > dmr_pkg::HALF_DIGIT)
                   || ((rem_reg == dmr_pkg::HALF_DIGIT) && mant_reg[0]);

    always_comb
    begin
        mant_next  = mant_reg;
        scale_next = scale_reg;
        ovf_next   = ovf_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        if (cmd.load)
        begin
            mant_next  = {mant_word2, mant_word1, mant_word0};
            scale_next = scale_in;
            ovf_next   = 1'b0;
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
            idx_next = wide ? dmr_pkg::TOP_IDX_WIDE : dmr_pkg::TOP_IDX_NARROW;
        end
        if (cmd.div_step)
        begin
            mant_next[idx_reg*dmr_pkg::CHUNK_W +: dmr_pkg::CHUNK_W] = quot;
            rem_next = diff[dmr_pkg::DIGIT_W-1:0];
            idx_next = idx_reg - 1'b1;
        end
        if (cmd.round_step)
        begin
            mant_next  = mant_reg + dmr_pkg::MANT_W'(round_up);
            scale_next = scale_reg - 1'b1;
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        mant_reg  <= mant_next;
        scale_reg <= scale_next;
        ovf_reg   <= ovf_next;
        rem_reg   <= rem_next;
        idx_reg   <= idx_next;
        if (cmd.load)
        begin
            sign_reg <= sign_in;
        end
        if (cmd.out_load)
        begin
            res_low_reg   <= mant_reg[dmr_pkg::WORD_W-1:0];
            res_high_reg  <= mant_reg[dmr_pkg::FIT_W-1:dmr_pkg::WORD_W];
            scale_out_reg <= scale_reg[dmr_pkg::SCALE_OUT_W-1:0];
            sign_out_reg  <= sign_reg;
            ovf_out_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.need_step  = wide || (scale_reg > dmr_pkg::MAX_SCALE);
    assign sts.scale_zero = (scale_reg == '0);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign result_low  = res_low_reg;
    assign result_high = res_high_reg;
    assign scale_out   = scale_out_reg;
    assign sign_out    = sign_out_reg;
    assign overflow    = ovf_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/dmr_controller.sv
// ----------------------------------------------------------------------------
// Decimal mantissa rounding controller
// Sequences the check, chunk division and rounding steps of each item and
// hands the finished item to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmr_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire dmr_pkg::dmr_sts_t sts,
    output dmr_pkg::dmr_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_ROUND,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.need_step)
                begin
                    state_next = S_DONE;
                end
                else if (sts.scale_zero)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.idx_zero)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                state_next     = S_CHECK;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

    a_stall_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall_reg == (state_reg != S_IDLE))
        else $error("input stall disagrees with controller state");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_CHECK))
        else $error("accepted item did not enter the check state");

    a_last_chunk_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && sts.idx_zero) |=> (state_reg == S_ROUND))
        else $error("last chunk of a division not followed by rounding");

    a_round_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |=> (state_reg == S_CHECK))
        else $error("rounding step not followed by a check");

endmodule

`default_nettype wire

FILE: hw/rtl/decimal_mantissa_round_half_even_unit.sv
// ----------------------------------------------------------------------------
// Decimal mantissa round-half-even unit
// Reduces a 192-bit decimal mantissa to 96 bits and the scale to at most 28
// by repeated division by ten with round-half-even on each dropped digit.
// ----------------------------------------------------------------------------
// Each division by ten runs through the 16-bit chunk divider one chunk per
// cycle: a step checks, divides the chunks from the top one down and rounds,
// over all 12 chunks while the mantissa exceeds 96 bits and over the low 6
// once it fits. If the scale reaches zero first, overflow is flagged.
// One item is processed at a time.
// Reset is asynchronous and active low; it clears the controller and the
// output valid flag.
`default_nettype none

module decimal_mantissa_round_half_even_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [dmr_pkg::WORD_W-1:0]         mant_word0,
    input  wire logic [dmr_pkg::WORD_W-1:0]         mant_word1,
    input  wire logic [dmr_pkg::WORD_W-1:0]         mant_word2,
    input  wire logic [dmr_pkg::SCALE_IN_W-1:0]     scale_in,
    input  wire logic                               sign_in,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [dmr_pkg::WORD_W-1:0]              result_low,
    output logic [dmr_pkg::HIGH_W-1:0]              result_high,
    output logic [dmr_pkg::SCALE_OUT_W-1:0]         scale_out,
    output logic                                    sign_out,
    output logic                                    overflow
);

    dmr_pkg::dmr_cmd_t cmd;
    dmr_pkg::dmr_sts_t sts;

    dmr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dmr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .mant_word0  (mant_word0),
        .mant_word1  (mant_word1),
        .mant_word2  (mant_word2),
        .scale_in    (scale_in),
        .sign_in     (sign_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_low  (result_low),
        .result_high (result_high),
        .scale_out   (scale_out),
        .sign_out    (sign_out),
        .overflow    (overflow)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Decimal mantissa round-half-even unit testbench
// Sends 192-bit decimal mantissas with a sign and a scale, and checks each
// reduced 96-bit mantissa, scale, sign and overflow flag against an internal
// predictor. The predictor divides by ten and rounds half to even one digit at
// a time. Directed corner cases come first. Random phases follow, with no
// idling, with an idle sender, with a stalling receiver and with both. The
// run also holds the output off for a long stretch while items keep coming.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MANT_W      = dmr_pkg::MANT_W;
    localparam int WORD_W      = dmr_pkg::WORD_W;
    localparam int FIT_W       = dmr_pkg::FIT_W;
    localparam int HIGH_W      = dmr_pkg::HIGH_W;
    localparam int SCALE_IN_W  = dmr_pkg::SCALE_IN_W;
    localparam int SCALE_OUT_W = dmr_pkg::SCALE_OUT_W;

    localparam logic [SCALE_IN_W-1:0]       MAX_SCALE  = dmr_pkg::MAX_SCALE;
    localparam logic [dmr_pkg::DIGIT_W-1:0] HALF_DIGIT = dmr_pkg::HALF_DIGIT;

    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 2400;

    localparam logic [MANT_W-1:0] DECIMAL_BASE = MANT_W'(10);
    localparam logic [MANT_W-1:0] FIT_LIMIT    = MANT_W'(1) << FIT_W;
    localparam logic [MANT_W-1:0] FIT_MAX      = FIT_LIMIT - 1'b1;
    localparam logic [MANT_W-1:0] WORD_MAX     = (MANT_W'(1) << WORD_W) - 1'b1;
    localparam logic [MANT_W-1:0] MANT_ONES    = '1;

    typedef struct packed {
        logic [MANT_W-1:0]     mant;
        logic [SCALE_IN_W-1:0] scale;
        logic                  sign;
    } operand_t;

    typedef struct packed {
        logic [WORD_W-1:0]      low;
        logic [HIGH_W-1:0]      high;
        logic [SCALE_OUT_W-1:0] scale;
        logic                   sign;
        logic                   ovf;
    } reduced_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [WORD_W-1:0] mant_word0 = '0;
    logic [WORD_W-1:0] mant_word1 = '0;
    logic [WORD_W-1:0] mant_word2 = '0;
    logic [SCALE_IN_W-1:0] scale_in = '0;
    logic sign_in = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [WORD_W-1:0] result_low;
    logic [HIGH_W-1:0] result_high;
    logic [SCALE_OUT_W-1:0] scale_out;
    logic sign_out;
    logic overflow;

    operand_t operand_q[$];
    reduced_t reduced_q[$];

    logic in_accepted = 1'b0;
    logic hold_req = 1'b0;
    logic hold_on = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int failures = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int overflow_count = 0;
    int input_stall_cycles = 0;

    decimal_mantissa_round_half_even_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mant_word0  (mant_word0),
        .mant_word1  (mant_word1),
        .mant_word2  (mant_word2),
        .scale_in    (scale_in),
        .sign_in     (sign_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_low  (result_low),
        .result_high (result_high),
        .scale_out   (scale_out),
        .sign_out    (sign_out),
        .overflow    (overflow)
    );

    always #6 clk = ~clk;

    function automatic reduced_t round_half_even_reduce(logic [MANT_W-1:0] mant,
                                                        logic [SCALE_IN_W-1:0] scale,
                                                        logic sign);
        reduced_t r;
        logic [MANT_W-1:0] quot;
        logic [MANT_W-1:0] digit;
        logic ovf;
        ovf = 1'b0;
        while (!ovf && (mant[MANT_W-1:FIT_W] != '0 || scale > MAX_SCALE))
        begin
            if (scale == '0)
            begin
                ovf = 1'b1;
            end
            else
            begin
                quot = mant / DECIMAL_BASE;
                digit = mant - quot * DECIMAL_BASE;
                if (digit > MANT_W'(HALF_DIGIT) || (digit == MANT_W'(HALF_DIGIT) && quot[0]))
                begin
                    quot = quot + 1'b1;
                end
                mant = quot;
                scale = scale - 1'b1;
            end
        end
        r.low = mant[WORD_W-1:0];
        r.high = mant[FIT_W-1:WORD_W];
        r.scale = scale[SCALE_OUT_W-1:0];
        r.sign = sign;
        r.ovf = ovf;
        return r;
    endfunction

    function automatic logic [MANT_W-1:0] random_mant(int bits);
        logic [MANT_W-1:0] m;
        m = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        if (bits == 0)
        begin
            return '0;
        end
        m = m & (MANT_ONES >> (MANT_W - bits));
        m[bits-1] = 1'b1;
        return m;
    endfunction

    task automatic queue_operand(logic [MANT_W-1:0] mant, logic [SCALE_IN_W-1:0] scale,
                                 logic sign);
        operand_t op;
        op.mant = mant;
        op.scale = scale;
        op.sign = sign;
        operand_q.push_back(op);
    endtask

    task automatic queue_random(int count);
        int kind;
        int bits;
        logic [MANT_W-1:0] mant;
        logic [SCALE_IN_W-1:0] scale;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                mant = random_mant($urandom_range(FIT_W));
                scale = SCALE_IN_W'($urandom_range(40));
            end
            else if (kind < 65)
            begin
                mant = random_mant($urandom_range(MANT_W, FIT_W + 1));
                scale = SCALE_IN_W'($urandom_range(60));
            end
            else if (kind < 80)
            begin
                bits = $urandom_range(100);
                mant = random_mant(bits) * DECIMAL_BASE;
                mant = mant + (($urandom_range(1) != 0) ? MANT_W'(HALF_DIGIT)
                                                         : MANT_W'($urandom_range(9)));
                scale = (mant[MANT_W-1:FIT_W] != '0) ? SCALE_IN_W'($urandom_range(30, 1))
                                                     : MAX_SCALE + 1'b1;
            end
            else if (kind < 90)
            begin
                mant = (FIT_MAX - MANT_W'($urandom_range(20))) * DECIMAL_BASE
                       + MANT_W'($urandom_range(9));
                scale = SCALE_IN_W'($urandom_range(2));
            end
            else if (kind < 96)
            begin
                mant = random_mant(MANT_W);
                mant[MANT_W-1] = 1'($urandom_range(1));
                scale = SCALE_IN_W'($urandom_range(255));
            end
            else
            begin
                mant = random_mant($urandom_range(FIT_W));
                scale = SCALE_IN_W'($urandom_range(255));
            end
            queue_operand(mant, scale, 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_drained();
        while (operand_q.size() != 0 || in_valid || reduced_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(string what, logic [WORD_W-1:0] expected,
                               logic [WORD_W-1:0] actual);
        if (expected !== actual)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, expected,
                     actual);
        end
    endtask

    always @(negedge clk)
    begin
        operand_t next_op;
        if (rst_n)
        begin
            if (!in_valid || in_accepted)
            begin
                in_accepted = 1'b0;
                if (operand_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_op = operand_q.pop_front();
                    in_valid <= 1'b1;
                    mant_word0 <= next_op.mant[WORD_W-1:0];
                    mant_word1 <= next_op.mant[2*WORD_W-1:WORD_W];
                    mant_word2 <= next_op.mant[MANT_W-1:2*WORD_W];
                    scale_in <= next_op.scale;
                    sign_in <= next_op.sign;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        reduced_t exp_r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                in_accepted = 1'b1;
                accepted_count++;
                reduced_q.push_back(round_half_even_reduce({mant_word2, mant_word1, mant_word0},
                                                           scale_in, sign_in));
            end
            else if (in_valid)
            begin
                input_stall_cycles++;
            end
            if (out_valid && !out_stall)
            begin
                if (reduced_q.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result, expected none, actual %h_%h", $time,
                             result_high, result_low);
                end
                else
                begin
                    exp_r = reduced_q.pop_front();
                    checked_count++;
                    if (exp_r.ovf)
                    begin
                        overflow_count++;
                    end
                    check_field("result_low", exp_r.low, result_low);
                    check_field("result_high", WORD_W'(exp_r.high), WORD_W'(result_high));
                    check_field("scale_out", WORD_W'(exp_r.scale), WORD_W'(scale_out));
                    check_field("sign_out", WORD_W'(exp_r.sign), WORD_W'(sign_out));
                    check_field("overflow", WORD_W'(exp_r.ovf), WORD_W'(overflow));
                end
            end
        end
    end

    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_on = 1'b0;
    end

    initial
    begin
        #150_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        queue_operand('0, '0, 1'b0);
        queue_operand(FIT_MAX, MAX_SCALE, 1'b0);
        queue_operand(FIT_MAX, '0, 1'b1);
        queue_operand(FIT_LIMIT, '0, 1'b0);
        queue_operand(MANT_ONES, '0, 1'b1);
        queue_operand(MANT_ONES, 8'd255, 1'b1);
        queue_operand(MANT_ONES, MAX_SCALE + 1'b1, 1'b0);
        queue_operand(MANT_W'(15), MAX_SCALE + 1'b1, 1'b0);
        queue_operand(MANT_W'(25), MAX_SCALE + 1'b1, 1'b1);
        queue_operand(MANT_W'(26), MAX_SCALE + 1'b1, 1'b0);
        queue_operand(MANT_W'(24), MAX_SCALE + 1'b1, 1'b0);
        queue_operand(MANT_W'(5), MAX_SCALE + 1'b1, 1'b0);
        queue_operand(MANT_W'(35), MAX_SCALE + 2'd2, 1'b1);
        queue_operand(MANT_W'(1), 8'd255, 1'b0);
        queue_operand('0, 8'd255, 1'b1);
        queue_operand(FIT_LIMIT * DECIMAL_BASE + MANT_W'(HALF_DIGIT), 8'd1, 1'b0);
        queue_operand(FIT_MAX * DECIMAL_BASE + MANT_W'(HALF_DIGIT), 8'd1, 1'b0);
        queue_operand(FIT_MAX * DECIMAL_BASE + MANT_W'(4), 8'd1, 1'b1);
        queue_operand(WORD_MAX * DECIMAL_BASE + MANT_W'(9), MAX_SCALE + 1'b1, 1'b0);
        queue_operand(FIT_LIMIT, 8'd1, 1'b0);
        queue_operand(random_mant(MANT_W), 8'd200, 1'b0);

        hold_req = 1'b1;
        queue_random(330);
        wait_drained();

        send_idle_pct = 54;
        recv_stall_pct = 0;
        queue_random(400);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 54;
        queue_random(400);
        wait_drained();

        send_idle_pct = 15;
        recv_stall_pct = 15;
        queue_random(400);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Reduced %0d mantissas over four idling phases and a long output hold-off;",
                 accepted_count);
        $display("%0d results checked, %0d hit overflow, input held off on %0d cycles.",
                 checked_count, overflow_count, input_stall_cycles);
        if (failures == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
